// File: rtl/mcw_pkg.sv
// Shared constants, types and state encoding for the minimum covering window block.
package mcw_pkg;

	localparam int MAX_TEXT    = 1024;
	localparam int MAX_PATTERN = 256;
	localparam int ALPHABET    = 256;

	localparam int SYM_W   = 8;
	localparam int ADDR_W  = $clog2(ALPHABET);
	localparam int TEXT_AW = $clog2(MAX_TEXT);
	localparam int PTR_W   = TEXT_AW + 1;
	localparam int PSIZE_W = $clog2(MAX_PATTERN) + 1;
	localparam int NEED_W  = PTR_W + 1;

	localparam logic MODE_PATTERN = 1'b0;
	localparam logic MODE_TEXT    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_PAT_UPD,
		ST_TXT_UPD,
		ST_CHECK,
		ST_LEFT_SYM,
		ST_LEFT_UPD,
		ST_EMIT
	} mcw_state_t;

	typedef struct packed {
		logic load_item;
		logic pat_read;
		logic pat_write;
		logic txt_write;
		logic txt_upd;
		logic win_record;
		logic left_read;
		logic left_upd;
		logic set_ovf;
		logic clear;
	} mcw_cmd_t;

	typedef struct packed {
		logic mode;
		logic last;
		logic late_pattern;
		logic pat_full;
		logic txt_full;
		logic no_pattern;
		logic covers;
	} mcw_stat_t;

endpackage

// File: rtl/mcw_datapath.sv
// Datapath: item registers, count table, text buffer, window pointers and best window.
module mcw_datapath import mcw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mcw_cmd_t             cmd,
	input  logic                 mode_in,
	input  logic [SYM_W-1:0]     symbol_in,
	input  logic                 last_in,
	output mcw_stat_t            stat,
	output logic                 found,
	output logic [TEXT_AW-1:0]   window_start,
	output logic [PTR_W-1:0]     window_length,
	output logic                 overflow
);

	logic                     mode_q;
	logic [SYM_W-1:0]         sym_q;
	logic                     last_q;

	logic [PTR_W-1:0]         rp_q;
	logic [PTR_W-1:0]         lp_q;
	logic [PSIZE_W-1:0]       psize_q;
	logic [PSIZE_W-1:0]       covered_q;
	logic [TEXT_AW-1:0]       best_start_q;
	logic [PTR_W-1:0]         best_len_q;
	logic                     best_vld_q;
	logic                     ovf_q;

	logic signed [NEED_W-1:0] need_mem [ALPHABET];
	logic [ALPHABET-1:0]      need_vld_q;
	logic signed [NEED_W-1:0] need_rd_q;
	logic                     need_rd_vld_q;
	logic [SYM_W-1:0]         text_mem [MAX_TEXT];
	logic [SYM_W-1:0]         text_rd_q;

	logic [ADDR_W-1:0]        need_raddr;
	logic                     need_re;
	logic [ADDR_W-1:0]        need_waddr;
	logic                     need_we;
	logic signed [NEED_W-1:0] need_wdata;
	logic signed [NEED_W-1:0] need_eff;
	logic signed [NEED_W-1:0] need_inc;
	logic signed [NEED_W-1:0] need_dec;
	logic [PTR_W-1:0]         win_len;
	logic                     better;

	// An entry not written since the last job clear reads as zero.
	assign need_eff = need_rd_vld_q ? need_rd_q : '0;
	assign need_inc = need_eff + NEED_W'(1);
	assign need_dec = need_eff - NEED_W'(1);
	assign win_len  = rp_q - lp_q;
	assign better   = !best_vld_q || (win_len < best_len_q);

	always_comb begin
		need_raddr = cmd.left_read ? ADDR_W'(text_rd_q) : ADDR_W'(sym_q);
		need_re    = cmd.pat_read || cmd.txt_write || cmd.left_read;
		need_waddr = cmd.left_upd ? ADDR_W'(text_rd_q) : ADDR_W'(sym_q);
		need_we    = cmd.pat_write || cmd.txt_upd || cmd.left_upd;
		need_wdata = cmd.txt_upd ? need_dec : need_inc;
	end

	always_ff @(posedge clk) begin
		if (need_we) begin
			need_mem[need_waddr] <= need_wdata;
		end
		if (need_re) begin
			need_rd_q <= need_mem[need_raddr];
		end
		if (cmd.txt_write) begin
			text_mem[rp_q[TEXT_AW-1:0]] <= sym_q;
		end
		if (cmd.win_record) begin
			text_rd_q <= text_mem[lp_q[TEXT_AW-1:0]];
		end
		if (cmd.load_item) begin
			mode_q <= mode_in;
			sym_q  <= symbol_in;
			last_q <= last_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_vld_q    <= '0;
			need_rd_vld_q <= 1'b0;
		end else begin
			if (need_re) begin
				need_rd_vld_q <= need_vld_q[need_raddr];
			end
			if (cmd.clear) begin
				need_vld_q <= '0;
			end else if (need_we) begin
				need_vld_q[need_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q         <= '0;
			lp_q         <= '0;
			psize_q      <= '0;
			covered_q    <= '0;
			best_start_q <= '0;
			best_len_q   <= '1;
			best_vld_q   <= 1'b0;
			ovf_q        <= 1'b0;
		end else if (cmd.clear) begin
			rp_q         <= '0;
			lp_q         <= '0;
			psize_q      <= '0;
			covered_q    <= '0;
			best_start_q <= '0;
			best_len_q   <= '1;
			best_vld_q   <= 1'b0;
			ovf_q        <= 1'b0;
		end else begin
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.pat_write) begin
				psize_q <= psize_q + PSIZE_W'(1);
			end
			if (cmd.txt_write) begin
				rp_q <= rp_q + PTR_W'(1);
			end
			if (cmd.txt_upd && (need_eff > 0)) begin
				covered_q <= covered_q + PSIZE_W'(1);
			end
			if (cmd.win_record && better) begin
				best_vld_q   <= 1'b1;
				best_len_q   <= win_len;
				best_start_q <= lp_q[TEXT_AW-1:0];
			end
			if (cmd.left_upd) begin
				lp_q <= lp_q + PTR_W'(1);
				if (need_inc > 0) begin
					covered_q <= covered_q - PSIZE_W'(1);
				end
			end
		end
	end

	always_comb begin
		stat.mode         = mode_q;
		stat.last         = last_q;
		stat.late_pattern = (rp_q != '0);
		stat.pat_full     = (psize_q >= PSIZE_W'(MAX_PATTERN));
		stat.txt_full     = (rp_q >= PTR_W'(MAX_TEXT));
		stat.no_pattern   = (psize_q == '0);
		stat.covers       = (covered_q == psize_q) && (lp_q < rp_q);
	end

	assign found         = best_vld_q && !ovf_q;
	assign window_start  = found ? best_start_q : '0;
	assign window_length = found ? best_len_q : '0;
	assign overflow      = ovf_q;

endmodule

// File: rtl/mcw_ctrl.sv
// Controller state machine that sequences pattern loads, text steps and window shrinking.
module mcw_ctrl import mcw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  mcw_stat_t stat,
	output mcw_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	mcw_state_t state_q;
	mcw_state_t state_d;
	mcw_state_t finish_st;

	assign finish_st = stat.last ? ST_EMIT : ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (stat.mode == MODE_PATTERN) begin
					if (stat.late_pattern || stat.pat_full) state_d = finish_st;
					else state_d = ST_PAT_UPD;
				end else begin
					if (stat.txt_full || stat.no_pattern) state_d = finish_st;
					else state_d = ST_TXT_UPD;
				end
			end
			ST_PAT_UPD:  state_d = finish_st;
			ST_TXT_UPD:  state_d = ST_CHECK;
			ST_CHECK: begin
				if (stat.covers) state_d = ST_LEFT_SYM;
				else state_d = finish_st;
			end
			ST_LEFT_SYM: state_d = ST_LEFT_UPD;
			ST_LEFT_UPD: state_d = ST_CHECK;
			ST_EMIT:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy          = 1'b0;
				cmd.load_item = start;
			end
			ST_DECODE: begin
				if (stat.mode == MODE_PATTERN) begin
					cmd.set_ovf  = !stat.late_pattern && stat.pat_full;
					cmd.pat_read = !stat.late_pattern && !stat.pat_full;
				end else begin
					cmd.set_ovf   = stat.txt_full;
					cmd.txt_write = !stat.txt_full;
				end
			end
			ST_PAT_UPD:  cmd.pat_write = 1'b1;
			ST_TXT_UPD:  cmd.txt_upd = 1'b1;
			ST_CHECK:    cmd.win_record = stat.covers;
			ST_LEFT_SYM: cmd.left_read = 1'b1;
			ST_LEFT_UPD: cmd.left_upd = 1'b1;
			ST_EMIT: begin
				done      = 1'b1;
				cmd.clear = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

endmodule

// File: rtl/minimum_covering_window_core.sv
// Top level of the minimum covering window block.
//
// Usage: an item is accepted at a rising edge with start high and busy low.
// Items with mode low load pattern bytes, which are counted per byte value.
// Items with mode high are text bytes; each is buffered and runs one
// two-pointer step that grows the window on the right and then shrinks it
// from the left while it still covers the pattern, tracking the shortest.
// The item with last high produces one result: done pulses for exactly one
// cycle with found, window_start, window_length and overflow valid in that
// cycle. The receiver cannot stall; the result must be taken when shown.
// After the result the job state is cleared and the next job may begin.
// Sequence: busy stays high while an item is worked. A loaded pattern byte reads
// then writes its count table entry. A pattern byte after text or with the pattern
// full, and a text byte with the buffer full or the pattern empty, is only decoded.
// A text byte is stored while its entry is read, then the entry is written and the
// window checked; a covering check records the window and reads its leftmost byte,
// whose entry is read and written as it is dropped before the next check. Each
// text byte is dropped at most once. The result state follows the last item's steps.
// Reset: arst_n clears the controller, the pointers and the table valid bits.
module minimum_covering_window_core import mcw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 mode,
	input  logic [SYM_W-1:0]     symbol,
	input  logic                 last,
	output logic                 done,
	output logic                 found,
	output logic [TEXT_AW-1:0]   window_start,
	output logic [PTR_W-1:0]     window_length,
	output logic                 overflow
);

	mcw_cmd_t  cmd;
	mcw_stat_t stat;

	mcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mcw_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.mode_in       (mode),
		.symbol_in     (symbol),
		.last_in       (last),
		.stat          (stat),
		.found         (found),
		.window_start  (window_start),
		.window_length (window_length),
		.overflow      (overflow)
	);

endmodule

// File: rtl/mcw_checker.sv
// Port-level checker for the minimum covering window block, with its bind.
module mcw_checker import mcw_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               found,
	input logic [PTR_W-1:0]   window_length,
	input logic               overflow
);

	// A result is shown for one cycle only.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// An accepted item always makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepting an item");

	// No new item can be taken while a result is shown.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while not busy");

	// A found window is never empty.
	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (window_length != '0))
		else $error("found window with zero length");

	// Overflow invalidates the result.
	a_ovf_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> !found)
		else $error("found reported together with overflow");

endmodule

bind minimum_covering_window_core mcw_checker u_mcw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.found         (found),
	.window_length (window_length),
	.overflow      (overflow)
);
